@@ rtl/core/wall_column_texel_mapper_defines.svh @@
// assertion macros for the wall column texel mapper
`ifndef WALL_COLUMN_TEXEL_MAPPER_DEFINES_SVH
`define WALL_COLUMN_TEXEL_MAPPER_DEFINES_SVH
`ifndef SYNTH
`define WCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WCM_ASSERT_LAT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##PIPE_LAT (cons)) \
    else $error(msg);
`else
`define WCM_ASSERT_NOW(lbl, ante, cons, msg)
`define WCM_ASSERT_LAT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/wcm_pkg.sv @@
// shared types and constants of the wall column texel mapper
package wcm_pkg;

    localparam int COORD_FRAC_BITS  = 8;
    localparam int TEXTURE_DIM_BITS = 12;
    localparam int MOD_STEPS        = 16;
    localparam int DIV_STEPS        = 12;
    localparam int PIPE_LAT         = MOD_STEPS + DIV_STEPS + 4;

    localparam logic [2:0] CFG_TILE_SIZE     = 3'd0;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_TEX_WIDTHS    = 3'd3;
    localparam logic [2:0] CFG_TEX_HEIGHTS   = 3'd4;

    localparam logic [2:0] SIDE_1 = 3'd1;
    localparam logic [2:0] SIDE_2 = 3'd2;
    localparam logic [2:0] SIDE_3 = 3'd3;
    localparam logic [2:0] SIDE_4 = 3'd4;

    // beat leaving the input stage
    typedef struct packed {
        logic        side_ok;
        logic [1:0]  tex_idx;
        logic        mirror;
        logic [10:0] tile;
        logic [11:0] tw;
        logic [11:0] th;
        logic [7:0]  hit_frac;
        logic [15:0] hit_int;
        logic        n2_neg;
        logic [24:0] n2_mag;
        logic [24:0] den_y;
        logic [11:0] row;
        logic [11:0] col;
        logic        pix_ok;
    } in_beat_t;

    // beat moving through the tile remainder cells
    typedef struct packed {
        logic        side_ok;
        logic [1:0]  tex_idx;
        logic        mirror;
        logic [10:0] tile;
        logic [11:0] tw;
        logic [11:0] th;
        logic [7:0]  hit_frac;
        logic [15:0] dvd;
        logic [10:0] rem;
        logic        n2_neg;
        logic [36:0] ny;
        logic [24:0] den_y;
        logic [11:0] row;
        logic [11:0] col;
        logic        pix_ok;
    } mod_beat_t;

    // beat moving through the divider cells
    typedef struct packed {
        logic        side_ok;
        logic [1:0]  tex_idx;
        logic [11:0] tw;
        logic [11:0] th;
        logic [18:0] tq;
        logic [18:0] rx;
        logic [11:0] bx;
        logic [11:0] qx;
        logic [24:0] den_y;
        logic [24:0] ry;
        logic [11:0] by;
        logic [11:0] qy;
        logic        y_ovf;
        logic        n2_neg;
        logic [11:0] row;
        logic [11:0] col;
        logic        pix_ok;
    } div_beat_t;

    // face code to texture number
    function automatic logic [1:0] tex_of_side(input logic [2:0] side);
        logic [1:0] idx;
        begin
            unique case (side)
                SIDE_2:  idx = 2'd2;
                SIDE_3:  idx = 2'd1;
                SIDE_4:  idx = 2'd3;
                default: idx = 2'd0;
            endcase
            return idx;
        end
    endfunction

endpackage

@@ rtl/core/wcm_mod_cell.sv @@
// one restoring remainder step of the hit coordinate by the tile size
module wcm_mod_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  wcm_pkg::mod_beat_t in_beat,
    output logic               out_valid,
    output wcm_pkg::mod_beat_t out_beat
);
    import wcm_pkg::*;

    logic      valid_reg;
    mod_beat_t beat_reg;
    mod_beat_t beat_next;
    logic [11:0] trial;

    // shift one dividend bit in, subtract the tile when it fits
    always_comb
    begin
        beat_next = in_beat;
        trial = {in_beat.rem, in_beat.dvd[15]};
        if (trial >= {1'b0, in_beat.tile})
        begin
            beat_next.rem = 11'(trial - {1'b0, in_beat.tile});
        end
        else
        begin
            beat_next.rem = trial[10:0];
        end
        beat_next.dvd = {in_beat.dvd[14:0], 1'b0};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

@@ rtl/core/wcm_div_cell.sv @@
// one restoring quotient step for both texel coordinates
module wcm_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  wcm_pkg::div_beat_t in_beat,
    output logic               out_valid,
    output wcm_pkg::div_beat_t out_beat
);
    import wcm_pkg::*;

    logic      valid_reg;
    div_beat_t beat_reg;
    div_beat_t beat_next;
    logic [19:0] trial_x;
    logic [25:0] trial_y;
    logic        bit_x;
    logic        bit_y;

    always_comb
    begin
        beat_next = in_beat;
        // column quotient bit
        trial_x = {in_beat.rx, in_beat.bx[11]};
        bit_x = (trial_x >= {1'b0, in_beat.tq});
        if (bit_x)
        begin
            beat_next.rx = 19'(trial_x - {1'b0, in_beat.tq});
        end
        else
        begin
            beat_next.rx = trial_x[18:0];
        end
        beat_next.bx = {in_beat.bx[10:0], 1'b0};
        beat_next.qx = {in_beat.qx[10:0], bit_x};
        // row quotient bit
        trial_y = {in_beat.ry, in_beat.by[11]};
        bit_y = (trial_y >= {1'b0, in_beat.den_y});
        if (bit_y)
        begin
            beat_next.ry = 25'(trial_y - {1'b0, in_beat.den_y});
        end
        else
        begin
            beat_next.ry = trial_y[24:0];
        end
        beat_next.by = {in_beat.by[10:0], 1'b0};
        beat_next.qy = {in_beat.qy[10:0], bit_y};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

@@ rtl/core/wall_column_texel_mapper.sv @@
// top level of the wall column texel mapper
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  item     | start, busy            | hit_side hit_x hit_y wall_height top_row row column
//  result   | done (one-cycle strobe)| texture_index texel_x texel_y texel_in_range
//           |                        | pixel_row pixel_column pixel_in_range
//  config   | cfg_valid, cfg_ready   | cfg_index cfg_data
//
// one beat per clock; busy stays low, a new item can start every cycle
// each result passes from its start through the input stage, multiply stage,
// 16 tile remainder cells, multiply stage, 12 divider cells, output register
// latency is set by the remainder and divider cell chains
// rst_n clears the valid bits of every stage and loads the register defaults
// the receiver cannot stall, so nothing is held back
module wall_column_texel_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  hit_side,
    input  logic [23:0] hit_x,
    input  logic [23:0] hit_y,
    input  logic [23:0] wall_height,
    input  logic signed [12:0] top_row,
    input  logic [11:0] row,
    input  logic [11:0] column,
    output logic        done,
    output logic [1:0]  texture_index,
    output logic [11:0] texel_x,
    output logic [11:0] texel_y,
    output logic        texel_in_range,
    output logic [11:0] pixel_row,
    output logic [11:0] pixel_column,
    output logic        pixel_in_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import wcm_pkg::*;
`include "wall_column_texel_mapper_defines.svh"

    // configuration registers
    logic [10:0] tile_size_reg;
    logic [11:0] window_height_reg;
    logic [11:0] window_width_reg;
    logic [47:0] tex_widths_reg;
    logic [47:0] tex_heights_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg     <= 11'd64;
            window_height_reg <= 12'd600;
            window_width_reg  <= 12'd800;
            tex_widths_reg    <= {4{12'd64}};
            tex_heights_reg   <= {4{12'd64}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TILE_SIZE:     tile_size_reg     <= cfg_data[10:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[11:0];
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[11:0];
                CFG_TEX_WIDTHS:    tex_widths_reg    <= cfg_data;
                CFG_TEX_HEIGHTS:   tex_heights_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input stage: face decode, sizes and row numerator
    in_beat_t    s0_next;
    in_beat_t    s0_reg;
    logic        s0_valid_reg;
    logic [1:0]  idx;
    logic [23:0] hit_sel;
    logic [23:0] wd;
    logic [19:0] whq;
    logic [23:0] adj;
    logic [13:0] diff;
    logic [25:0] n2;

    always_comb
    begin
        idx     = tex_of_side(hit_side);
        hit_sel = (hit_side <= SIDE_2) ? hit_y : hit_x;
        wd      = (wall_height == 24'd0) ? 24'd1 : wall_height;
        whq     = {window_height_reg, 8'b0};
        adj     = (wd >= {4'b0, whq}) ? 24'(wd - {4'b0, whq}) : 24'd0;
        diff    = 14'({2'b0, row} - {top_row[12], top_row});
        n2      = 26'({{3{diff[13]}}, diff, 9'b0} + {2'b0, adj});

        s0_next.side_ok  = (hit_side >= SIDE_1) && (hit_side <= SIDE_4);
        s0_next.tex_idx  = idx;
        s0_next.mirror   = (hit_side == SIDE_1) || (hit_side == SIDE_3);
        s0_next.tile     = (tile_size_reg == 11'd0) ? 11'd1 : tile_size_reg;
        s0_next.tw       = tex_widths_reg[idx * TEXTURE_DIM_BITS +: TEXTURE_DIM_BITS];
        s0_next.th       = tex_heights_reg[idx * TEXTURE_DIM_BITS +: TEXTURE_DIM_BITS];
        s0_next.hit_frac = hit_sel[7:0];
        s0_next.hit_int  = hit_sel[23:8];
        s0_next.n2_neg   = n2[25];
        s0_next.n2_mag   = n2[25] ? 25'(-n2) : n2[24:0];
        s0_next.den_y    = {wd, 1'b0};
        s0_next.row      = row;
        s0_next.col      = column;
        s0_next.pix_ok   = (column < window_width_reg) && (row < window_height_reg);
    end

    // row numerator product
    mod_beat_t s1_next;
    mod_beat_t s1_reg;
    logic      s1_valid_reg;

    always_comb
    begin
        s1_next.side_ok  = s0_reg.side_ok;
        s1_next.tex_idx  = s0_reg.tex_idx;
        s1_next.mirror   = s0_reg.mirror;
        s1_next.tile     = s0_reg.tile;
        s1_next.tw       = s0_reg.tw;
        s1_next.th       = s0_reg.th;
        s1_next.hit_frac = s0_reg.hit_frac;
        s1_next.dvd      = s0_reg.hit_int;
        s1_next.rem      = 11'd0;
        s1_next.n2_neg   = s0_reg.n2_neg;
        s1_next.ny       = {12'b0, s0_reg.n2_mag} * {25'b0, s0_reg.th};
        s1_next.den_y    = s0_reg.den_y;
        s1_next.row      = s0_reg.row;
        s1_next.col      = s0_reg.col;
        s1_next.pix_ok   = s0_reg.pix_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

    // tile remainder chain
    logic      mod_valid [MOD_STEPS+1];
    mod_beat_t mod_beat  [MOD_STEPS+1];

    assign mod_valid[0] = s1_valid_reg;
    assign mod_beat[0]  = s1_reg;

    for (genvar i = 0; i < MOD_STEPS; i++)
    begin : g_mod
        wcm_mod_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mod_valid[i]),
            .in_beat   (mod_beat[i]),
            .out_valid (mod_valid[i+1]),
            .out_beat  (mod_beat[i+1])
        );
    end

    // mirror, column product and row overflow check
    mod_beat_t   m_last;
    div_beat_t   s2_next;
    div_beat_t   s2_reg;
    logic        s2_valid_reg;
    logic [18:0] f0;
    logic [18:0] tq;
    logic [18:0] fm;
    logic [30:0] nx;
    logic        ovf;

    assign m_last = mod_beat[MOD_STEPS];

    always_comb
    begin
        f0  = {m_last.rem, m_last.hit_frac};
        tq  = {m_last.tile, 8'b0};
        fm  = m_last.mirror ? 19'(tq - f0) : f0;
        nx  = {12'b0, fm} * {19'b0, m_last.tw};
        ovf = (m_last.ny >= {m_last.den_y, 12'b0});

        s2_next.side_ok = m_last.side_ok;
        s2_next.tex_idx = m_last.tex_idx;
        s2_next.tw      = m_last.tw;
        s2_next.th      = m_last.th;
        s2_next.tq      = tq;
        s2_next.rx      = nx[30:12];
        s2_next.bx      = nx[11:0];
        s2_next.qx      = 12'd0;
        s2_next.den_y   = m_last.den_y;
        s2_next.ry      = ovf ? 25'd0 : m_last.ny[36:12];
        s2_next.by      = m_last.ny[11:0];
        s2_next.qy      = 12'd0;
        s2_next.y_ovf   = ovf;
        s2_next.n2_neg  = m_last.n2_neg;
        s2_next.row     = m_last.row;
        s2_next.col     = m_last.col;
        s2_next.pix_ok  = m_last.pix_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= mod_valid[MOD_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    // divider chain
    logic      div_valid [DIV_STEPS+1];
    div_beat_t div_beat  [DIV_STEPS+1];

    assign div_valid[0] = s2_valid_reg;
    assign div_beat[0]  = s2_reg;

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        wcm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[j]),
            .in_beat   (div_beat[j]),
            .out_valid (div_valid[j+1]),
            .out_beat  (div_beat[j+1])
        );
    end

    // result formatting
    div_beat_t   d_last;
    logic        y_neg;
    logic [1:0]  tex_next;
    logic [11:0] tx_next;
    logic [11:0] ty_next;
    logic        tin_next;
    logic        done_reg;
    logic [1:0]  tex_reg;
    logic [11:0] tx_reg;
    logic [11:0] ty_reg;
    logic        tin_reg;
    logic [11:0] prow_reg;
    logic [11:0] pcol_reg;
    logic        pin_reg;

    assign d_last = div_beat[DIV_STEPS];

    always_comb
    begin
        y_neg = d_last.n2_neg && (d_last.y_ovf || (d_last.qy != 12'd0));
        if (d_last.side_ok)
        begin
            tex_next = d_last.tex_idx;
            tx_next  = d_last.qx;
            ty_next  = y_neg ? 12'd0 : (d_last.y_ovf ? 12'hFFF : d_last.qy);
            tin_next = (d_last.qx < d_last.tw) && !y_neg && !d_last.y_ovf
                       && (d_last.qy < d_last.th);
        end
        else
        begin
            tex_next = 2'd0;
            tx_next  = 12'd0;
            ty_next  = 12'd0;
            tin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        tex_reg  <= tex_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        tin_reg  <= tin_next;
        prow_reg <= d_last.row;
        pcol_reg <= d_last.col;
        pin_reg  <= d_last.pix_ok;
    end

    assign done           = done_reg;
    assign texture_index  = tex_reg;
    assign texel_x        = tx_reg;
    assign texel_y        = ty_reg;
    assign texel_in_range = tin_reg;
    assign pixel_row      = prow_reg;
    assign pixel_column   = pcol_reg;
    assign pixel_in_range = pin_reg;

    // checks
    `WCM_ASSERT_LAT(a_latency, start && !busy, done, "result strobe missing after start")
    `WCM_ASSERT_NOW(a_tx_in, done && texel_in_range, texel_x != 12'hFFF, "texel_x saturated in range")
    `WCM_ASSERT_NOW(a_ty_in, done && texel_in_range, texel_y != 12'hFFF, "texel_y saturated in range")
endmodule
